/* src/gb3_pkg.sv */
// ----------------------------------------------------------------------------
// gb3_pkg: shared constants for the 3x3 Gaussian blur unit
// Register indexes, configuration widths and reset values, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam int WIDTH_BITS     = 11;
  localparam int HEIGHT_BITS    = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

  // smallest frame edge the window needs
  localparam int MIN_EDGE = 3;

endpackage

`default_nettype wire

/* src/gb3_line_store.sv */
// ----------------------------------------------------------------------------
// gb3_line_store: dual line memory
// One entry per column holding the row above and the row two above; one
// write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/gb3_column_cell.sv */
// ----------------------------------------------------------------------------
// gb3_column_cell: one window column
// Holds top, middle and bottom pixels of one column, passes them on to the
// next cell on every shift and offers the 1-2-1 weighted column sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_column_cell #(
  parameter int PB = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                shift,
  input  wire logic [2:0][PB-1:0]  col_in,   // [0] top, [1] middle, [2] bottom
  output logic      [2:0][PB-1:0]  col_out,
  output logic      [PB+1:0]       col_sum
);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

  assign col_sum = {2'b00, col_out[0]} + {1'b0, col_out[1], 1'b0} + {2'b00, col_out[2]};

endmodule

`default_nettype wire

/* src/gaussian_blur_3x3_unit.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_unit: streaming 3x3 Gaussian blur, kernel 1-2-1/2-4-2/1-2-1
// Takes grayscale pixels in raster order and emits the blurred interior,
// (width-2) by (height-2) pixels, with row and frame marks.
//
// Usage:
//   s_* carries input pixels, one word each, in raster order.
//   m_* carries blurred pixels; m_tlast marks the last pixel of an output
//   row, m_tuser the last pixel of the frame.
//   cfg_we/cfg_index/cfg_wdata write image_width (index 0) and image_height
//   (index 1); a write restarts the frame at row 0, column 0. Write only
//   while no word is in flight.
//   Throughput is one pixel per clock while the result side does not stall.
//   A result reaches the output register by way of the sum stage: the line
//   memory read and pixel capture happen as the completing input word is
//   taken, and the window sum is loaded into the output register after that.
//   Pixels in the first two rows and first two columns produce no output.
//   Reset clears the counters, window cells and pipeline valids and sets
//   640x480; line memory contents are not cleared (every entry is written
//   before it is used). When m_tready is low, one word waits in the output
//   register and one more in the sum stage; s_tready then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_unit #(
  parameter int MAX_WIDTH  = gb3_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = gb3_pkg::PIXEL_BITS_DEF,
  localparam int TDW = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [TDW-1:0]                   s_tdata,   // pixel_in
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic      [TDW-1:0]                   m_tdata,   // pixel_out
  output logic                                  m_tlast,   // end_of_row
  output logic                                  m_tuser,   // end_of_frame
  input  wire logic                             cfg_we,
  input  wire logic [gb3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [gb3_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  import gb3_pkg::*;

  localparam int PB = PIXEL_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int UW = CW + 1;
  localparam int KW = (UW > WIDTH_BITS) ? UW : WIDTH_BITS;
  localparam int SW = PB + 4;

  // configuration
  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [KW-1:0]          width_use;
  logic [HEIGHT_BITS-1:0] height_use;
  logic [KW-1:0]          width_ext;

  // position counters
  logic [CW-1:0]          col;
  logic [HEIGHT_BITS-1:0] row;
  logic [CW-1:0]          col_cur;
  logic [HEIGHT_BITS-1:0] row_cur;
  logic [CW-1:0]          col_next;
  logic [HEIGHT_BITS-1:0] row_next;
  logic                   col_last;
  logic                   row_last;

  // sum stage
  logic                   b_valid;
  logic                   b_emit;
  logic                   b_eor;
  logic                   b_eof;
  logic [PB-1:0]          b_pix;
  logic [CW-1:0]          b_col;
  logic                   b_go;
  logic [2*PB-1:0]        store_rd;
  logic [2:0][PB-1:0]     col_new;
  logic [2:0][PB-1:0]     col_prev;
  logic [2:0][PB-1:0]     col_old;
  logic [PB+1:0]          sum_prev;
  logic [PB+1:0]          sum_old;
  logic [PB+1:0]          sum_new;
  logic [SW-1:0]          win_sum;

  logic                   in_fire;
  logic                   out_load;

  assign width_ext = KW'(image_width);

  always_comb begin
    priority if (width_ext < KW'(MIN_EDGE)) begin
      width_use = KW'(MIN_EDGE);
    end else if (width_ext > KW'(MAX_WIDTH)) begin
      width_use = KW'(MAX_WIDTH);
    end else begin
      width_use = width_ext;
    end
  end

  assign height_use = (image_height < HEIGHT_BITS'(MIN_EDGE)) ? HEIGHT_BITS'(MIN_EDGE)
                                                                : image_height;

  // counters can sit past a narrowed frame only in odd cases; fold them back
  assign col_cur  = (KW'(col) >= width_use) ? '0 : col;
  assign row_cur  = (row >= height_use) ? '0 : row;
  assign col_last = (KW'(col_cur) == width_use - KW'(1));
  assign row_last = (row_cur == height_use - HEIGHT_BITS'(1));

  always_comb begin
    col_next = col_cur + CW'(1);
    row_next = row_cur;
    if (col_last) begin
      col_next = '0;
      row_next = row_last ? '0 : row_cur + HEIGHT_BITS'(1);
    end
  end

  // handshakes
  assign b_go     = b_valid && (!b_emit || !m_tvalid || m_tready);
  assign s_tready = !b_valid || b_go;
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = b_go && b_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // read stage: memory read and pixel capture
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_fire) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_pix  <= s_tdata[PB-1:0];
      b_col  <= col_cur;
      b_emit <= (row_cur >= HEIGHT_BITS'(2)) && (col_cur >= CW'(2));
      b_eor  <= col_last;
      b_eof  <= col_last && row_last;
    end
  end

  gb3_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PB),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col_cur),
    .rd_data (store_rd),
    .wr_en   (b_go),
    .wr_addr (b_col),
    .wr_data ({store_rd[PB-1:0], b_pix})
  );

  // newest column: top from two rows up, middle from the row above
  assign col_new[0] = store_rd[2*PB-1:PB];
  assign col_new[1] = store_rd[PB-1:0];
  assign col_new[2] = b_pix;

  gb3_column_cell #(.PB(PB)) u_cell_prev (
    .clk     (clk),
    .rst     (rst),
    .shift   (b_go),
    .col_in  (col_new),
    .col_out (col_prev),
    .col_sum (sum_prev)
  );

  gb3_column_cell #(.PB(PB)) u_cell_old (
    .clk     (clk),
    .rst     (rst),
    .shift   (b_go),
    .col_in  (col_prev),
    .col_out (col_old),
    .col_sum (sum_old)
  );

  assign sum_new = {2'b00, col_new[0]} + {1'b0, col_new[1], 1'b0} + {2'b00, col_new[2]};
  assign win_sum = SW'(sum_old) + {1'b0, sum_prev, 1'b0} + SW'(sum_new);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= TDW'(win_sum[SW-1:4]);
      m_tlast <= b_eor;
      m_tuser <= b_eof;
    end
  end

endmodule

`default_nettype wire

/* bench/gb3_blur_checker.sv */
// ----------------------------------------------------------------------------
// gb3_blur_checker: prediction and comparison for the 3x3 Gaussian blur unit
// Watches the pixel, result and register write channels, keeps its own line
// stores, window and raster position, and compares every result word with
// the oldest predicted word.
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_blur_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  input  wire logic                               s_tready,
  input  wire logic [7:0]                         s_tdata,   // pixel_in
  input  wire logic                               m_tvalid,
  input  wire logic                               m_tready,
  input  wire logic [7:0]                         m_tdata,   // pixel_out
  input  wire logic                               m_tlast,   // end_of_row
  input  wire logic                               m_tuser,   // end_of_frame
  input  wire logic                               cfg_we,
  input  wire logic [gb3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [gb3_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output int                                      mismatches,
  output int                                      words_owed,
  output int                                      words_checked,
  output int                                      frames_closed
);
  timeunit 1ns;
  timeprecision 1ps;
  import gb3_pkg::*;

  localparam int PIX_BITS    = PIXEL_BITS_DEF;
  localparam int REPORT_LIMIT = 30;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel;
    logic                row_end;
    logic                frame_end;
  } blur_word_t;

  logic [PIX_BITS-1:0]    row_above     [MAX_WIDTH_DEF];
  logic [PIX_BITS-1:0]    row_two_above [MAX_WIDTH_DEF];
  logic [PIX_BITS-1:0]    win [6];
  logic [WIDTH_BITS-1:0]  width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;
  int                     col;
  int                     row;
  blur_word_t             expected_blur [$];
  int                     fails;
  int                     checked;
  int                     frames;
  int                     reports;

  // one input pixel: queue the blurred word it completes, then shift the window
  task automatic blur_next_pixel(input logic [PIX_BITS-1:0] px);
    int                  w;
    int                  h;
    int                  total;
    logic [PIX_BITS-1:0] mid;
    logic [PIX_BITS-1:0] top;
    blur_word_t          word;
    w = (int'(width_reg) < MIN_EDGE) ? MIN_EDGE :
        (int'(width_reg) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(width_reg);
    h = (int'(height_reg) < MIN_EDGE) ? MIN_EDGE : int'(height_reg);
    if (col >= w) col = 0;
    if (row >= h) row = 0;
    mid = row_above[col];
    top = row_two_above[col];
    if (row >= 2 && col >= 2) begin
      // window cells 0..2 are the column two left, 3..5 one left; top to bottom
      total = win[0] + top + win[2] + px
            + 2 * (win[1] + mid + win[3] + win[5])
            + 4 * win[4];
      word.pixel     = PIX_BITS'(total >> 4);
      word.row_end   = (col == w - 1);
      word.frame_end = word.row_end && (row == h - 1);
      expected_blur.push_back(word);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = px;
    row_two_above[col] = mid;
    row_above[col]     = px;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  always @(posedge clk) begin
    blur_word_t want;
    if (rst) begin
      expected_blur.delete();
      foreach (win[i]) win[i] = '0;
      col        = 0;
      row        = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      fails      = 0;
      checked    = 0;
      frames     = 0;
      reports    = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_blur.size() == 0) begin
          fails++;
          if (reports < REPORT_LIMIT) begin
            reports++;
            $display("%0t: result word with nothing expected: got pixel %0d last %b user %b",
                     $time, m_tdata, m_tlast, m_tuser);
          end
        end else begin
          want = expected_blur.pop_front();
          checked++;
          if (want.frame_end) frames++;
          if (m_tdata[PIX_BITS-1:0] !== want.pixel || m_tlast !== want.row_end ||
              m_tuser !== want.frame_end) begin
            fails++;
            if (reports < REPORT_LIMIT) begin
              reports++;
              $display("%0t: mismatch: expected pixel %0d row_end %b frame_end %b, got %0d %b %b",
                       $time, want.pixel, want.row_end, want.frame_end,
                       m_tdata, m_tlast, m_tuser);
            end
          end
        end
      end
      // a write restarts the raster; the line stores keep their contents
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          width_reg = cfg_wdata[WIDTH_BITS-1:0];
        end else if (cfg_index == REG_IMAGE_HEIGHT) begin
          height_reg = cfg_wdata[HEIGHT_BITS-1:0];
        end
        col = 0;
        row = 0;
      end
      if (s_tvalid && s_tready) blur_next_pixel(s_tdata[PIX_BITS-1:0]);
    end
    mismatches    <= fails;
    words_owed    <= expected_blur.size();
    words_checked <= checked;
    frames_closed <= frames;
  end

endmodule

`default_nettype wire

/* bench/gaussian_blur_3x3_unit_test.sv */
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_unit_test: stimulus and verdict for the 3x3 blur unit
// Streams directed and random frames through a range of image sizes,
// including clamped widths and heights and restarts by register write, with
// random gaps on the pixel side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gb3_pkg::*;

  localparam int PIX_BITS      = PIXEL_BITS_DEF;
  localparam int TDW           = ((PIX_BITS + 7) / 8) * 8;
  localparam int STALL_MAX     = 12;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_PIXELS = 600;
  // longest gap between two handshakes before the run is stopped with errors
  localparam int IDLE_LIMIT    = 1000;

  typedef enum {FILL_RANDOM, FILL_MAX, FILL_CHECKER} fill_t;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [TDW-1:0]            s_tdata;   // pixel_in
  logic                      m_tvalid;
  logic                      m_tready;
  logic [TDW-1:0]            m_tdata;   // pixel_out
  logic                      m_tlast;   // end_of_row
  logic                      m_tuser;   // end_of_frame
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata;

  int mismatches;
  int words_owed;
  int words_checked;
  int frames_closed;

  bit                     steady = 1'b0;
  int                     idle_cycles = 0;
  int                     pixels_sent = 0;
  int                     settings_written = 0;
  logic [WIDTH_BITS-1:0]  cur_w = WIDTH_RESET;
  logic [HEIGHT_BITS-1:0] cur_h = HEIGHT_RESET;

  gaussian_blur_3x3_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gb3_blur_checker blur_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .words_owed    (words_owed),
    .words_checked (words_checked),
    .frames_closed (frames_closed)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("gaussian_blur_3x3_unit_test: errors");
      $finish;
    end
  end

  // result side: stall a random number of cycles before each word
  initial begin
    int stall;
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
    end
  end

  function automatic logic [PIX_BITS-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_BITS'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_BITS-1:0] px);
    int gap;
    gap = steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDW'(px);
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    pixels_sent++;
  endtask

  // drop valid, wait for every predicted word, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input bit do_w, input bit do_h, input logic [WIDTH_BITS-1:0] w,
                           input logic [HEIGHT_BITS-1:0] h);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_IMAGE_WIDTH;
      // bits above the width field carry noise
      cfg_wdata <= CFG_DATA_BITS'({$urandom, w});
      cur_w = w;
      @(posedge clk);
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_IMAGE_HEIGHT;
      cfg_wdata <= CFG_DATA_BITS'(h);
      cur_h = h;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_written++;
    @(posedge clk);
  endtask

  task automatic run_phase(input bit do_w, input bit do_h, input logic [WIDTH_BITS-1:0] w,
                           input logic [HEIGHT_BITS-1:0] h, input int npix, input fill_t fill);
    logic [PIX_BITS-1:0] px;
    settle();
    configure(do_w, do_h, w, h);
    for (int i = 0; i < npix; i++) begin
      case (fill)
        FILL_MAX:     px = '1;
        FILL_CHECKER: px = i[0] ? '1 : '0;
        default:      px = pick_pixel();
      endcase
      send_pixel(px);
    end
  endtask

  initial begin
    int                     sel;
    int                     start;
    int                     we;
    int                     he;
    int                     frame;
    int                     npix;
    bit                     do_w;
    bit                     do_h;
    logic [WIDTH_BITS-1:0]  nw;
    logic [HEIGHT_BITS-1:0] nh;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // smallest frame at full scale, then clamped sizes, then a cut-short frame
    run_phase(1'b1, 1'b1, 11'd3, 16'd3, 9, FILL_MAX);
    run_phase(1'b1, 1'b1, 11'd0, 16'd1, 9, FILL_CHECKER);
    run_phase(1'b0, 1'b1, 11'd0, 16'd2, 4, FILL_RANDOM);

    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      sel = $urandom_range(0, 9);
      nw  = (sel < 7) ? WIDTH_BITS'($urandom_range(3, 10)) :
            (sel < 8) ? WIDTH_BITS'($urandom_range(0, 2)) : WIDTH_BITS'($urandom_range(11, 40));
      sel = $urandom_range(0, 9);
      nh  = (sel < 7) ? HEIGHT_BITS'($urandom_range(3, 6)) :
            (sel < 8) ? HEIGHT_BITS'($urandom_range(0, 2)) :
            (sel < 9) ? '1 : HEIGHT_BITS'($urandom_range(7, 40));
      sel  = $urandom_range(0, 9);
      do_w = (sel != 0);
      do_h = (sel != 1);
      if (!do_w) nw = cur_w;
      if (!do_h) nh = cur_h;
      we = (int'(nw) < MIN_EDGE) ? MIN_EDGE :
           (int'(nw) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(nw);
      he = (int'(nh) < MIN_EDGE) ? MIN_EDGE : int'(nh);
      frame = we * he;
      sel   = $urandom_range(0, 9);
      if (frame <= 240 && sel < 7) begin
        npix = frame * $urandom_range(1, 2);
      end else if (frame <= 240) begin
        npix = $urandom_range(1, frame * 2);
      end else begin
        // frames over 240 pixels: three to six rows, ending anywhere in a row
        npix = we * $urandom_range(3, 6) + $urandom_range(0, we - 1);
      end
      steady = ($urandom_range(0, 3) == 0);
      run_phase(do_w, do_h, nw, nh, npix, FILL_RANDOM);
    end

    // tallest height on a narrow image, then part of a first row at the widest clamped width
    steady = 1'b0;
    run_phase(1'b1, 1'b1, 11'd1, '1, 3 * 7 + 2, FILL_RANDOM);
    run_phase(1'b1, 1'b1, '1, 16'd3, 40, FILL_RANDOM);
    settle();

    $display("%0d pixels streamed over %0d register settings, clamped and wide sizes included",
             pixels_sent, settings_written);
    $display("%0d blurred words compared, %0d frame ends among them",
             words_checked, frames_closed);
    if (mismatches == 0 && words_owed == 0) begin
      $display("gaussian_blur_3x3_unit_test: clean");
    end else begin
      $display("gaussian_blur_3x3_unit_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* gaussian_blur_3x3_unit.f */
src/gb3_pkg.sv
src/gb3_line_store.sv
src/gb3_column_cell.sv
src/gaussian_blur_3x3_unit.sv
bench/gb3_blur_checker.sv
bench/gaussian_blur_3x3_unit_test.sv
